// ----- src/sbe_mdd_pkg.sv -----
// Package for the market data decoder: record layout, codes, template tables.
// Used by every file under src; no dependencies.
package sbe_mdd_pkg;

	localparam int OFFSET_WIDTH = 32;
	localparam int OUT_DEPTH    = 8;
	localparam int CFG_IDX_W    = 4;

	localparam logic [15:0] TPL_TRADES = 16'd10000;
	localparam logic [15:0] TPL_BBA    = 16'd10001;
	localparam logic [15:0] TPL_SNAP   = 16'd10002;
	localparam logic [15:0] TPL_DIFF   = 16'd10003;

	localparam logic [5:0] ROOT_TRADES = 6'd18;
	localparam logic [5:0] ROOT_BBA    = 6'd50;
	localparam logic [5:0] ROOT_SNAP   = 6'd18;
	localparam logic [5:0] ROOT_DIFF   = 6'd26;
	localparam logic [15:0] ENTRY_TRADE = 16'd25;
	localparam logic [15:0] ENTRY_LEVEL = 16'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCHEMA  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = CFG_IDX_W'(1);

	localparam logic [2:0] KIND_HDR    = 3'd0;
	localparam logic [2:0] KIND_TRADE  = 3'd1;
	localparam logic [2:0] KIND_BID    = 3'd2;
	localparam logic [2:0] KIND_ASK    = 3'd3;
	localparam logic [2:0] KIND_SYM    = 3'd4;
	localparam logic [2:0] KIND_STATUS = 3'd5;

	localparam logic [2:0] MT_UNKNOWN = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_SCHEMA    = 3'd3;
	localparam logic [2:0] ST_LAYOUT    = 3'd4;

	typedef enum logic [7:0] {
		PH_HDR   = 8'b0000_0001,
		PH_ROOT  = 8'b0000_0010,
		PH_GHDR  = 8'b0000_0100,
		PH_ENTRY = 8'b0000_1000,
		PH_SLEN  = 8'b0001_0000,
		PH_SYM   = 8'b0010_0000,
		PH_DONE  = 8'b0100_0000,
		PH_SKIP  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [15:0] schema;
		logic [15:0] version;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  mtype;
		logic [63:0] first;
		logic [63:0] second;
		logic [63:0] third;
		logic [7:0]  pexp;
		logic [7:0]  qexp;
		logic [7:0]  bm;
		logic [7:0]  ch;
		logic [2:0]  st;
		logic        last;
	} rec_t;

	function automatic logic [2:0] type_of(logic [15:0] t);
		logic [15:0] d;
		d = t - TPL_TRADES;
		if (t >= TPL_TRADES && t <= TPL_DIFF) return d[2:0];
		return MT_UNKNOWN;
	endfunction

	function automatic logic [5:0] root_size(logic [15:0] t);
		if (t == TPL_TRADES) return ROOT_TRADES;
		if (t == TPL_BBA) return ROOT_BBA;
		if (t == TPL_SNAP) return ROOT_SNAP;
		return ROOT_DIFF;
	endfunction

	// header + root + minimal group header / symbol length
	function automatic logic [5:0] min_len(logic [15:0] t);
		if (t == TPL_TRADES) return 6'd8 + ROOT_TRADES + 6'd6;
		if (t == TPL_BBA) return 6'd8 + ROOT_BBA + 6'd1;
		if (t == TPL_SNAP) return 6'd8 + ROOT_SNAP + 6'd9;
		return 6'd8 + ROOT_DIFF + 6'd9;
	endfunction

endpackage

// ----- src/sbe_mdd_decoder.sv -----
// Byte-level parser: input register, parse state and record generation.
// Depends on sbe_mdd_pkg.
module sbe_mdd_decoder #(
	parameter int OFFSET_WIDTH = sbe_mdd_pkg::OFFSET_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [7:0]         in_byte,
	input  logic               in_end,
	input  sbe_mdd_pkg::cfg_t  cfg,
	output logic               valid_s1,
	output logic               wa_valid,
	output sbe_mdd_pkg::rec_t  wa_rec,
	output logic               wb_valid,
	output sbe_mdd_pkg::rec_t  wb_rec
);

	typedef logic [2:0][63:0] lanes_t;

	logic [7:0] byte_s1;
	logic       end_s1;

	logic [OFFSET_WIDTH-1:0] off_q, off_n;
	sbe_mdd_pkg::phase_t     phase_q, phase_n;
	logic [15:0] tpl_q, tpl_n;
	logic [63:0] asm_q, asm_n;
	logic [63:0] time_q, time_n, second_q, second_n, third_q, third_n;
	logic [7:0]  pe_q, pe_n, qe_q, qe_n;
	logic [15:0] stride_q, stride_n;
	logic [31:0] ent_q, ent_n;
	logic [15:0] epos_q, epos_n;
	logic        side_q, side_n;
	logic [7:0]  sym_q, sym_n;
	logic [2:0]  stat_q, stat_n;
	lanes_t      lanes_q, lanes_n;
	logic [5:0]  need_q, need_n;

	function automatic lanes_t lane_put(lanes_t l, logic [4:0] pos, logic [7:0] v);
		lanes_t r;
		r = l;
		r[pos[4:3]] = r[pos[4:3]] | ({56'b0, v} << {pos[2:0], 3'b000});
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

	always_comb begin
		logic [15:0] blk;
		logic [15:0] tpl;
		logic [7:0]  o;
		logic [7:0]  pe_off;
		logic [15:0] gsize;
		logic [31:0] num;
		logic        do_after;
		logic [2:0]  st;
		lanes_t      lt;

		off_n = off_q; phase_n = phase_q; tpl_n = tpl_q; asm_n = asm_q;
		time_n = time_q; second_n = second_q; third_n = third_q;
		pe_n = pe_q; qe_n = qe_q; stride_n = stride_q; ent_n = ent_q;
		epos_n = epos_q; side_n = side_q; sym_n = sym_q; stat_n = stat_q;
		lanes_n = lanes_q; need_n = need_q;
		wa_valid = 1'b0; wa_rec = '0; wb_valid = 1'b0; wb_rec = '0;
		blk = asm_q[15:0]; tpl = asm_q[31:16]; o = off_q[7:0];
		pe_off = 8'd24; gsize = 16'd4; num = '0; do_after = 1'b0;
		st = sbe_mdd_pkg::ST_OK; lt = lanes_q;

		if (valid_s1) begin
			case (phase_q)
				sbe_mdd_pkg::PH_HDR: begin
					asm_n = asm_q | ({56'b0, byte_s1} << {off_q[2:0], 3'b000});
					if (off_q == OFFSET_WIDTH'(7)) begin
						blk = asm_n[15:0];
						tpl = asm_n[31:16];
						need_n = '0;
						if (asm_n[47:32] != cfg.schema || asm_n[63:48] != cfg.version) begin
							stat_n = sbe_mdd_pkg::ST_SCHEMA;
							phase_n = sbe_mdd_pkg::PH_SKIP;
						end else begin
							tpl_n = tpl;
							if (sbe_mdd_pkg::type_of(tpl) == sbe_mdd_pkg::MT_UNKNOWN) begin
								stat_n = sbe_mdd_pkg::ST_UNKNOWN;
								phase_n = sbe_mdd_pkg::PH_SKIP;
							end else if (blk < {10'b0, sbe_mdd_pkg::root_size(tpl)}) begin
								stat_n = sbe_mdd_pkg::ST_LAYOUT;
								phase_n = sbe_mdd_pkg::PH_SKIP;
							end else begin
								need_n = sbe_mdd_pkg::min_len(tpl);
								phase_n = sbe_mdd_pkg::PH_ROOT;
							end
						end
					end
				end
				sbe_mdd_pkg::PH_ROOT: begin
					pe_off = (tpl_q == sbe_mdd_pkg::TPL_DIFF) ? 8'd32 : 8'd24;
					if (o <= 8'd15) begin
						time_n = time_q | ({56'b0, byte_s1} << {o[2:0], 3'b000});
					end else if (o <= 8'd23) begin
						second_n = second_q | ({56'b0, byte_s1} << {o[2:0], 3'b000});
					end else if (tpl_q == sbe_mdd_pkg::TPL_DIFF && o <= 8'd31) begin
						third_n = third_q | ({56'b0, byte_s1} << {o[2:0], 3'b000});
					end else if (o == pe_off) begin
						pe_n = byte_s1;
					end else if (o == pe_off + 8'd1) begin
						qe_n = byte_s1;
						wa_valid = 1'b1;
						wa_rec.kind = sbe_mdd_pkg::KIND_HDR;
						wa_rec.first = time_q;
						wa_rec.second = second_q;
						wa_rec.third = third_q;
						wa_rec.pexp = pe_q;
						wa_rec.qexp = byte_s1;
					end else if (tpl_q == sbe_mdd_pkg::TPL_BBA && o <= 8'd41) begin
						lt = lane_put(lanes_q, 5'(o - 8'd18), byte_s1);
						lanes_n = lt;
						if (o == 8'd41) begin
							wa_valid = 1'b1;
							wa_rec.kind = sbe_mdd_pkg::KIND_BID;
							wa_rec.second = lt[1];
							wa_rec.third = lt[2];
							wa_rec.pexp = pe_q;
							wa_rec.qexp = qe_q;
							lanes_n = '0;
						end
					end else if (tpl_q == sbe_mdd_pkg::TPL_BBA && o <= 8'd57) begin
						lt = lane_put(lanes_q, 5'(o - 8'd34), byte_s1);
						lanes_n = lt;
						if (o == 8'd57) begin
							wa_valid = 1'b1;
							wa_rec.kind = sbe_mdd_pkg::KIND_ASK;
							wa_rec.second = lt[1];
							wa_rec.third = lt[2];
							wa_rec.pexp = pe_q;
							wa_rec.qexp = qe_q;
							lanes_n = '0;
						end
					end
					if (o == 8'd7 + {2'b0, sbe_mdd_pkg::root_size(tpl_q)}) begin
						if (tpl_q == sbe_mdd_pkg::TPL_BBA) begin
							phase_n = sbe_mdd_pkg::PH_SLEN;
						end else begin
							side_n = 1'b0;
							phase_n = sbe_mdd_pkg::PH_GHDR;
							epos_n = '0;
							asm_n = '0;
						end
					end
				end
				sbe_mdd_pkg::PH_GHDR: begin
					gsize = (tpl_q == sbe_mdd_pkg::TPL_TRADES) ? 16'd6 : 16'd4;
					asm_n = asm_q | ({56'b0, byte_s1} << {epos_q[2:0], 3'b000});
					if (epos_q + 16'd1 < gsize) begin
						epos_n = epos_q + 16'd1;
					end else begin
						blk = asm_n[15:0];
						num = (tpl_q == sbe_mdd_pkg::TPL_TRADES) ? asm_n[47:16]
							: {16'b0, asm_n[31:16]};
						if (blk < ((tpl_q == sbe_mdd_pkg::TPL_TRADES) ?
								sbe_mdd_pkg::ENTRY_TRADE : sbe_mdd_pkg::ENTRY_LEVEL)) begin
							stat_n = sbe_mdd_pkg::ST_LAYOUT;
							phase_n = sbe_mdd_pkg::PH_SKIP;
						end else begin
							stride_n = blk;
							ent_n = num;
							epos_n = '0;
							lanes_n = '0;
							if (num == '0) do_after = 1'b1;
							else phase_n = sbe_mdd_pkg::PH_ENTRY;
						end
					end
				end
				sbe_mdd_pkg::PH_ENTRY: begin
					if (tpl_q == sbe_mdd_pkg::TPL_TRADES) begin
						if (epos_q < 16'd24) begin
							lanes_n = lane_put(lanes_q, epos_q[4:0], byte_s1);
						end else if (epos_q == 16'd24) begin
							wa_valid = 1'b1;
							wa_rec.kind = sbe_mdd_pkg::KIND_TRADE;
							wa_rec.first = lanes_q[0];
							wa_rec.second = lanes_q[1];
							wa_rec.third = lanes_q[2];
							wa_rec.pexp = pe_q;
							wa_rec.qexp = qe_q;
							wa_rec.bm = byte_s1;
						end
					end else begin
						if (epos_q < 16'd16) begin
							lt = lane_put(lanes_q, epos_q[4:0] + 5'd8, byte_s1);
							lanes_n = lt;
						end
						if (epos_q == 16'd15) begin
							wa_valid = 1'b1;
							wa_rec.kind = side_q ? sbe_mdd_pkg::KIND_ASK : sbe_mdd_pkg::KIND_BID;
							wa_rec.second = lt[1];
							wa_rec.third = lt[2];
							wa_rec.pexp = pe_q;
							wa_rec.qexp = qe_q;
						end
					end
					if ({1'b0, epos_q} + 17'd1 >= {1'b0, stride_q}) begin
						lanes_n = '0;
						epos_n = '0;
						ent_n = ent_q - 32'd1;
						if (ent_n == '0) do_after = 1'b1;
					end else begin
						epos_n = epos_q + 16'd1;
					end
				end
				sbe_mdd_pkg::PH_SLEN: begin
					sym_n = byte_s1;
					phase_n = (byte_s1 == 8'd0) ? sbe_mdd_pkg::PH_DONE : sbe_mdd_pkg::PH_SYM;
				end
				sbe_mdd_pkg::PH_SYM: begin
					wa_valid = 1'b1;
					wa_rec.kind = sbe_mdd_pkg::KIND_SYM;
					wa_rec.ch = byte_s1;
					sym_n = sym_q - 8'd1;
					if (sym_n == 8'd0) phase_n = sbe_mdd_pkg::PH_DONE;
				end
				default: begin
				end
			endcase

			if (do_after) begin
				if (tpl_q != sbe_mdd_pkg::TPL_TRADES && !side_q) begin
					side_n = 1'b1;
					phase_n = sbe_mdd_pkg::PH_GHDR;
					epos_n = '0;
					asm_n = '0;
				end else begin
					phase_n = sbe_mdd_pkg::PH_SLEN;
				end
			end

			wa_rec.mtype = sbe_mdd_pkg::type_of(tpl_n);
			if (off_q != '1) off_n = off_q + OFFSET_WIDTH'(1);

			if (end_s1) begin
				if (phase_n == sbe_mdd_pkg::PH_HDR) st = sbe_mdd_pkg::ST_TRUNC;
				else if (({1'b0, off_q} + (OFFSET_WIDTH+1)'(1)) < (OFFSET_WIDTH+1)'(need_n))
					st = sbe_mdd_pkg::ST_TRUNC;
				else if (stat_n != sbe_mdd_pkg::ST_OK) st = stat_n;
				else if (phase_n == sbe_mdd_pkg::PH_DONE) st = sbe_mdd_pkg::ST_OK;
				else st = sbe_mdd_pkg::ST_TRUNC;
				wb_valid = 1'b1;
				wb_rec.kind = sbe_mdd_pkg::KIND_STATUS;
				wb_rec.mtype = sbe_mdd_pkg::type_of(tpl_n);
				wb_rec.st = st;
				wb_rec.last = 1'b1;
				off_n = '0; phase_n = sbe_mdd_pkg::PH_HDR; tpl_n = '0; asm_n = '0;
				time_n = '0; second_n = '0; third_n = '0; pe_n = '0; qe_n = '0;
				stride_n = '0; ent_n = '0; epos_n = '0; side_n = 1'b0; sym_n = '0;
				stat_n = sbe_mdd_pkg::ST_OK; lanes_n = '0; need_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; phase_q <= sbe_mdd_pkg::PH_HDR; tpl_q <= '0; asm_q <= '0;
			time_q <= '0; second_q <= '0; third_q <= '0; pe_q <= '0; qe_q <= '0;
			stride_q <= '0; ent_q <= '0; epos_q <= '0; side_q <= 1'b0; sym_q <= '0;
			stat_q <= sbe_mdd_pkg::ST_OK; lanes_q <= '0; need_q <= '0;
		end else begin
			off_q <= off_n; phase_q <= phase_n; tpl_q <= tpl_n; asm_q <= asm_n;
			time_q <= time_n; second_q <= second_n; third_q <= third_n;
			pe_q <= pe_n; qe_q <= qe_n; stride_q <= stride_n; ent_q <= ent_n;
			epos_q <= epos_n; side_q <= side_n; sym_q <= sym_n; stat_q <= stat_n;
			lanes_q <= lanes_n; need_q <= need_n;
		end
	end

endmodule

// ----- src/sbe_mdd_out_fifo.sv -----
// Result queue: takes up to two records per cycle, delivers one per transfer.
// Depends on sbe_mdd_pkg.
module sbe_mdd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wa_valid,
	input  sbe_mdd_pkg::rec_t wa_rec,
	input  logic              wb_valid,
	input  sbe_mdd_pkg::rec_t wb_rec,
	input  logic              rd_en,
	output logic              rd_valid,
	output sbe_mdd_pkg::rec_t rd_rec,
	output logic [$clog2(sbe_mdd_pkg::OUT_DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(sbe_mdd_pkg::OUT_DEPTH);
	localparam int CW = $clog2(sbe_mdd_pkg::OUT_DEPTH+1);

	sbe_mdd_pkg::rec_t mem_q [sbe_mdd_pkg::OUT_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [1:0]    npush;

	assign pop = rd_en && (cnt_q != '0);
	assign npush = {1'b0, wa_valid} + {1'b0, wb_valid};
	assign rd_valid = (cnt_q != '0);
	assign rd_rec = mem_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (wa_valid) mem_q[wp_q] <= wa_rec;
		if (wb_valid) mem_q[wa_valid ? wp_q + PW'(1) : wp_q] <= wb_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PW'(npush);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(npush) - CW'(pop);
		end
	end

endmodule

// ----- src/sbe_mdd_config.sv -----
// Configuration registers: expected schema id and version.
// Depends on sbe_mdd_pkg.
module sbe_mdd_config (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [sbe_mdd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                       wr_data,
	output sbe_mdd_pkg::cfg_t                 cfg
);

	sbe_mdd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.schema <= 16'd1;
			cfg_q.version <= 16'd0;
		end else if (wr_en) begin
			case (wr_index)
				sbe_mdd_pkg::CFG_SCHEMA:  cfg_q.schema <= wr_data;
				sbe_mdd_pkg::CFG_VERSION: cfg_q.version <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/sbe_market_data_decoder_unit.sv -----
// Top level of the market data decoder: config registers, parser, result queue.
// Depends on sbe_mdd_pkg, sbe_mdd_config, sbe_mdd_decoder, sbe_mdd_out_fifo.
//
// Usage:
//  - Input channel (in_valid/in_ready): one message byte per transfer,
//    msg_end set on the last byte of a message.
//  - Output channel (out_valid/out_ready): one record per transfer: a header
//    record, trade or level records, symbol bytes, and a status record
//    (run_last = 1) for the byte marked msg_end.
//  - Config channel (cfg_valid/cfg_ready): index 0 expected schema,
//    index 1 expected version; always ready. Write only while idle.
//  - Throughput: one byte per cycle sustained while the queue has room. A
//    byte goes into an input register, is parsed in the next cycle and its
//    records land in an 8-entry queue; its first record is on the output
//    once it has been written into the queue.
//  - The final byte of a message can produce two records; the queue absorbs
//    them and in_ready drops only when fewer than two free slots would remain.
//  - Receiver stall: records wait in the queue; input stops when it fills.
//  - Reset: parse state cleared, schema 1, version 0, queue empty.
module sbe_market_data_decoder_unit #(
	parameter int OFFSET_WIDTH = sbe_mdd_pkg::OFFSET_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        msg_byte,
	input  logic                              msg_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        rec_kind,
	output logic [2:0]                        msg_type,
	output logic signed [63:0]                first_value,
	output logic signed [63:0]                second_value,
	output logic signed [63:0]                third_value,
	output logic signed [7:0]                 price_exp,
	output logic signed [7:0]                 qty_exp,
	output logic [7:0]                        buyer_maker,
	output logic [7:0]                        symbol_char,
	output logic [2:0]                        status,
	output logic                              run_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbe_mdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                       cfg_data
);

	localparam int CW = $clog2(sbe_mdd_pkg::OUT_DEPTH+1);

	sbe_mdd_pkg::cfg_t cfg;
	sbe_mdd_pkg::rec_t wa_rec, wb_rec, rd_rec;
	logic              wa_valid, wb_valid, valid_s1, in_fire;
	logic [CW-1:0]     count;

	assign cfg_ready = 1'b1;
	// room for two records of the byte in s1 plus two of the new byte
	assign in_ready = ({1'b0, count} + (valid_s1 ? (CW+1)'(2) : (CW+1)'(0)) + (CW+1)'(2))
		<= (CW+1)'(sbe_mdd_pkg::OUT_DEPTH);
	assign in_fire = in_valid && in_ready;

	sbe_mdd_config u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sbe_mdd_decoder #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_byte  (msg_byte),
		.in_end   (msg_end),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.wa_valid (wa_valid),
		.wa_rec   (wa_rec),
		.wb_valid (wb_valid),
		.wb_rec   (wb_rec)
	);

	sbe_mdd_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wa_valid (wa_valid),
		.wa_rec   (wa_rec),
		.wb_valid (wb_valid),
		.wb_rec   (wb_rec),
		.rd_en    (out_ready),
		.rd_valid (out_valid),
		.rd_rec   (rd_rec),
		.count    (count)
	);

	assign rec_kind     = rd_rec.kind;
	assign msg_type     = rd_rec.mtype;
	assign first_value  = rd_rec.first;
	assign second_value = rd_rec.second;
	assign third_value  = rd_rec.third;
	assign price_exp    = rd_rec.pexp;
	assign qty_exp      = rd_rec.qexp;
	assign buyer_maker  = rd_rec.bm;
	assign symbol_char  = rd_rec.ch;
	assign status       = rd_rec.st;
	assign run_last     = rd_rec.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(sbe_mdd_pkg::OUT_DEPTH))
		else $error("result queue overflow");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_last == (rec_kind == sbe_mdd_pkg::KIND_STATUS)))
		else $error("run_last not tied to status record");

	a_held_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rec_kind))
		else $error("stalled record lost");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rec_kind <= sbe_mdd_pkg::KIND_STATUS)
		else $error("bad record kind");

endmodule

// ----- bench/sbe_market_data_decoder_unit_tb.sv -----
// Testbench for sbe_market_data_decoder_unit: builds encoded market data messages, predicts the
// decoded record stream in a bit-accurate model and checks every output record against it.
// Depends on sbe_mdd_pkg and the RTL under src.
module sbe_market_data_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_BYTES   = 300;

	// message faults injected by the generator
	localparam int F_NONE     = 0;
	localparam int F_SCHEMA   = 1;
	localparam int F_VERSION  = 2;
	localparam int F_TEMPLATE = 3;
	localparam int F_ROOTLEN  = 4;
	localparam int F_GROUPLEN = 5;
	localparam int F_CUT      = 6;
	localparam int F_SHORTHDR = 7;
	localparam int F_WIDE     = 8;
	localparam int F_TRAIL    = 9;
	localparam int F_NOISE    = 10;

	typedef enum logic [7:0] {
		S_HDR   = 8'b0000_0001,
		S_ROOT  = 8'b0000_0010,
		S_GHDR  = 8'b0000_0100,
		S_ENTRY = 8'b0000_1000,
		S_SLEN  = 8'b0001_0000,
		S_SYM   = 8'b0010_0000,
		S_DONE  = 8'b0100_0000,
		S_SKIP  = 8'b1000_0000
	} parse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] msg_byte = 8'd0;
	logic msg_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] rec_kind;
	logic [2:0] msg_type;
	logic signed [63:0] first_value;
	logic signed [63:0] second_value;
	logic signed [63:0] third_value;
	logic signed [7:0] price_exp;
	logic signed [7:0] qty_exp;
	logic [7:0] buyer_maker;
	logic [7:0] symbol_char;
	logic [2:0] status;
	logic run_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sbe_mdd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = 16'd0;

	sbe_market_data_decoder_unit dut (.*);

	initial forever #2 clk = ~clk;

	// decoder model state
	logic [15:0] cfg_schema = 16'd1;
	logic [15:0] cfg_version = 16'd0;
	logic [sbe_mdd_pkg::OFFSET_WIDTH-1:0] boff;
	parse_t pst;
	logic [15:0] tpl;
	logic [63:0] asm_r, h_time, h_sec, h_third;
	logic [7:0] h_pe, h_qe;
	logic [15:0] stride;
	logic [31:0] ent_left;
	logic [15:0] epos;
	bit side;
	logic [7:0] sym_left;
	logic [2:0] st_latch;
	logic [63:0] lane [3];
	int unsigned need;

	sbe_mdd_pkg::rec_t pending_recs[$];
	logic [7:0] wire_q[$];
	int errors = 0;
	int sent_bytes = 0;
	int gap_max = 4;
	int burst_left = 0;
	bit hold_req = 0;
	bit busy = 0;
	int idle_cyc = 0;

	function automatic logic [2:0] type_code(logic [15:0] t);
		if (t >= sbe_mdd_pkg::TPL_TRADES && t <= sbe_mdd_pkg::TPL_DIFF)
			return 3'(t - sbe_mdd_pkg::TPL_TRADES);
		return sbe_mdd_pkg::MT_UNKNOWN;
	endfunction

	function automatic int unsigned root_sz(logic [15:0] t);
		if (t == sbe_mdd_pkg::TPL_TRADES) return 18;
		if (t == sbe_mdd_pkg::TPL_BBA) return 50;
		if (t == sbe_mdd_pkg::TPL_SNAP) return 18;
		return 26;
	endfunction

	function automatic int unsigned min_sz(logic [15:0] t);
		if (t == sbe_mdd_pkg::TPL_TRADES) return 32;
		if (t == sbe_mdd_pkg::TPL_BBA) return 59;
		if (t == sbe_mdd_pkg::TPL_SNAP) return 35;
		return 43;
	endfunction

	task automatic push_rec(input logic [2:0] k, input logic [63:0] a, input logic [63:0] bv,
			input logic [63:0] c, input bit exps, input logic [7:0] bm, input logic [7:0] ch,
			input logic [2:0] st, input bit last);
		sbe_mdd_pkg::rec_t r;
		r.kind = k;
		r.mtype = type_code(tpl);
		r.first = a;
		r.second = bv;
		r.third = c;
		r.pexp = exps ? h_pe : 8'd0;
		r.qexp = exps ? h_qe : 8'd0;
		r.bm = bm;
		r.ch = ch;
		r.st = st;
		r.last = last;
		pending_recs = {pending_recs, r};
	endtask

	task automatic lane_put(input int unsigned pos, input logic [7:0] b);
		lane[(pos >> 3) % 3] |= 64'(b) << (8 * (pos % 8));
	endtask

	task automatic clear_lanes();
		lane[0] = '0; lane[1] = '0; lane[2] = '0;
	endtask

	task automatic clear_state();
		boff = '0; pst = S_HDR; tpl = '0; asm_r = '0; h_time = '0; h_sec = '0;
		h_third = '0; h_pe = '0; h_qe = '0; stride = '0; ent_left = '0; epos = '0;
		side = 0; sym_left = '0; st_latch = sbe_mdd_pkg::ST_OK; need = 0;
		clear_lanes();
	endtask

	task automatic start_group();
		pst = S_GHDR;
		epos = '0;
		asm_r = '0;
	endtask

	task automatic after_group();
		if (tpl != sbe_mdd_pkg::TPL_TRADES && side == 0) begin
			side = 1;
			start_group();
		end else begin
			pst = S_SLEN;
		end
	endtask

	task automatic hdr_done();
		need = 0;
		if (asm_r[47:32] != cfg_schema || asm_r[63:48] != cfg_version) begin
			st_latch = sbe_mdd_pkg::ST_SCHEMA; pst = S_SKIP; return;
		end
		tpl = asm_r[31:16];
		if (type_code(tpl) == sbe_mdd_pkg::MT_UNKNOWN) begin
			st_latch = sbe_mdd_pkg::ST_UNKNOWN; pst = S_SKIP; return;
		end
		if (asm_r[15:0] < root_sz(tpl)) begin
			st_latch = sbe_mdd_pkg::ST_LAYOUT; pst = S_SKIP; return;
		end
		need = min_sz(tpl);
		pst = S_ROOT;
	endtask

	task automatic root_byte(input int unsigned o, input logic [7:0] b);
		bit diff;
		int unsigned pe;
		diff = (tpl == sbe_mdd_pkg::TPL_DIFF);
		pe = diff ? 32 : 24;
		if (o <= 15) h_time |= 64'(b) << (8 * (o % 8));
		else if (o <= 23) h_sec |= 64'(b) << (8 * (o % 8));
		else if (diff && o <= 31) h_third |= 64'(b) << (8 * (o % 8));
		else if (o == pe) h_pe = b;
		else if (o == pe + 1) begin
			h_qe = b;
			push_rec(sbe_mdd_pkg::KIND_HDR, h_time, h_sec, h_third, 1, 0, 0,
				sbe_mdd_pkg::ST_OK, 0);
		end else if (tpl == sbe_mdd_pkg::TPL_BBA && o <= 41) begin
			lane_put(o - 18, b);
			if (o == 41) begin
				push_rec(sbe_mdd_pkg::KIND_BID, 0, lane[1], lane[2], 1, 0, 0,
					sbe_mdd_pkg::ST_OK, 0);
				clear_lanes();
			end
		end else if (tpl == sbe_mdd_pkg::TPL_BBA && o <= 57) begin
			lane_put(o - 34, b);
			if (o == 57) begin
				push_rec(sbe_mdd_pkg::KIND_ASK, 0, lane[1], lane[2], 1, 0, 0,
					sbe_mdd_pkg::ST_OK, 0);
				clear_lanes();
			end
		end
		if (o == 7 + root_sz(tpl)) begin
			if (tpl == sbe_mdd_pkg::TPL_BBA) pst = S_SLEN;
			else begin
				side = 0;
				start_group();
			end
		end
	endtask

	task automatic group_hdr_byte(input logic [7:0] b);
		bit tr;
		int unsigned sz;
		logic [31:0] num;
		tr = (tpl == sbe_mdd_pkg::TPL_TRADES);
		sz = tr ? 6 : 4;
		asm_r |= 64'(b) << (8 * (epos % 8));
		if (epos + 1 < sz) begin
			epos++;
			return;
		end
		num = tr ? asm_r[47:16] : {16'd0, asm_r[31:16]};
		if (asm_r[15:0] < (tr ? 25 : 16)) begin
			st_latch = sbe_mdd_pkg::ST_LAYOUT; pst = S_SKIP; return;
		end
		stride = asm_r[15:0];
		ent_left = num;
		epos = '0;
		clear_lanes();
		if (num == 0) after_group();
		else pst = S_ENTRY;
	endtask

	task automatic entry_byte(input logic [7:0] b);
		int unsigned pos;
		pos = epos;
		if (tpl == sbe_mdd_pkg::TPL_TRADES) begin
			if (pos < 24) lane_put(pos, b);
			else if (pos == 24)
				push_rec(sbe_mdd_pkg::KIND_TRADE, lane[0], lane[1], lane[2], 1, b, 0,
					sbe_mdd_pkg::ST_OK, 0);
		end else begin
			if (pos < 16) lane_put(pos + 8, b);
			if (pos == 15)
				push_rec(side ? sbe_mdd_pkg::KIND_ASK : sbe_mdd_pkg::KIND_BID, 0, lane[1],
					lane[2], 1, 0, 0, sbe_mdd_pkg::ST_OK, 0);
		end
		if (pos + 1 >= stride) begin
			clear_lanes();
			epos = '0;
			ent_left--;
			if (ent_left == 0) after_group();
		end else begin
			epos = 16'(pos + 1);
		end
	endtask

	// expected records for one accepted byte
	task automatic decode_byte(input logic [7:0] b, input bit e);
		longint unsigned o;
		logic [2:0] st;
		o = boff;
		case (pst)
			S_HDR: begin
				asm_r |= 64'(b) << (8 * (o % 8));
				if (o >= 7) hdr_done();
			end
			S_ROOT: root_byte(int'(o % 256), b);
			S_GHDR: group_hdr_byte(b);
			S_ENTRY: entry_byte(b);
			S_SLEN: begin
				sym_left = b;
				pst = (b == 0) ? S_DONE : S_SYM;
			end
			S_SYM: begin
				push_rec(sbe_mdd_pkg::KIND_SYM, 0, 0, 0, 0, 0, b, sbe_mdd_pkg::ST_OK, 0);
				sym_left--;
				if (sym_left == 0) pst = S_DONE;
			end
			default: ;
		endcase
		if (boff != '1) boff++;
		if (e) begin
			if (pst == S_HDR) st = sbe_mdd_pkg::ST_TRUNC;
			else if (o + 1 < need) st = sbe_mdd_pkg::ST_TRUNC;
			else if (st_latch != sbe_mdd_pkg::ST_OK) st = st_latch;
			else if (pst == S_DONE) st = sbe_mdd_pkg::ST_OK;
			else st = sbe_mdd_pkg::ST_TRUNC;
			push_rec(sbe_mdd_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 0, st, 1);
			clear_state();
		end
	endtask

	function automatic void cmp(string nm, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", nm, e, a);
			errors++;
		end
	endfunction

	task automatic check_record();
		sbe_mdd_pkg::rec_t r;
		if (pending_recs.size() == 0) begin
			$error("record transfer with nothing expected: kind %0d", rec_kind);
			errors++;
			return;
		end
		r = pending_recs.pop_front();
		cmp("rec_kind", r.kind, rec_kind);
		cmp("msg_type", r.mtype, msg_type);
		cmp("first_value", r.first, first_value);
		cmp("second_value", r.second, second_value);
		cmp("third_value", r.third, third_value);
		cmp("price_exp", r.pexp, $unsigned(price_exp));
		cmp("qty_exp", r.qexp, $unsigned(qty_exp));
		cmp("buyer_maker", r.bm, buyer_maker);
		cmp("symbol_char", r.ch, symbol_char);
		cmp("status", r.st, status);
		cmp("run_last", r.last, run_last);
	endtask

	// handshake sampling at the falling edge, where everything is settled
	always @(negedge clk) begin
		busy = (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready);
		if (out_valid && out_ready) check_record();
	end

	always @(posedge clk) begin
		if (busy) idle_cyc = 0;
		else idle_cyc++;
		if (idle_cyc >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: stall rate is redrawn after each random-length run, plus a long hold on request
	initial begin
		int pct;
		int cnt;
		pct = 0;
		cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
			end else begin
				if (cnt == 0) begin
					cnt = $urandom_range(100, 400);
					case ($urandom_range(0, 3))
						0: pct = 0;
						1: pct = 20;
						2: pct = 50;
						default: pct = 85;
					endcase
				end
				cnt--;
				out_ready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	// called at a rising edge; returns at the rising edge of the transfer
	task automatic send_byte(input logic [7:0] b, input bit e);
		int n;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			n = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (n > 0) begin
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		msg_byte <= b;
		msg_end <= e;
		@(negedge clk);
		while (!(in_valid && in_ready)) @(negedge clk);
		decode_byte(b, e);
		sent_bytes++;
		@(posedge clk);
	endtask

	task automatic send_message();
		foreach (wire_q[i]) send_byte(wire_q[i], i == wire_q.size() - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sbe_mdd_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		if (idx == sbe_mdd_pkg::CFG_SCHEMA) cfg_schema = v;
		else if (idx == sbe_mdd_pkg::CFG_VERSION) cfg_version = v;
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic put_byte(input logic [7:0] v);
		wire_q = {wire_q, v};
	endtask

	task automatic put_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
	endtask

	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'h8000_0000_0000_0000;
			3: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic make_message(input logic [15:0] t, input int fault, input int max_ent);
		logic [15:0] blk, sch, ver, gs;
		int esz, nent, nsides, len, pad;
		wire_q.delete();
		if (fault == F_NOISE) begin
			repeat ($urandom_range(1, 30)) put_byte(8'($urandom));
			return;
		end
		blk = 16'(root_sz(t));
		if (fault == F_ROOTLEN) blk = 16'($urandom_range(0, root_sz(t) - 1));
		else if (fault == F_WIDE) blk += 16'($urandom_range(1, 40));
		sch = cfg_schema;
		ver = cfg_version;
		if (fault == F_SCHEMA) sch ^= 16'($urandom_range(1, 16'hffff));
		if (fault == F_VERSION) ver ^= 16'($urandom_range(1, 16'hffff));
		put_le(blk, 2); put_le(t, 2); put_le(sch, 2); put_le(ver, 2);
		put_le(pick64(), 8); put_le(pick64(), 8);
		if (t == sbe_mdd_pkg::TPL_DIFF) put_le(pick64(), 8);
		put_le($urandom, 1); put_le($urandom, 1);
		if (t == sbe_mdd_pkg::TPL_BBA) begin
			repeat (4) put_le(pick64(), 8);
		end else begin
			nsides = (t == sbe_mdd_pkg::TPL_TRADES) ? 1 : 2;
			esz = (t == sbe_mdd_pkg::TPL_TRADES) ? 25 : 16;
			for (int s = 0; s < nsides; s++) begin
				gs = 16'(esz);
				if (fault == F_WIDE) gs += 16'($urandom_range(1, 9));
				if (fault == F_GROUPLEN && s == nsides - 1)
					gs = 16'($urandom_range(0, esz - 1));
				nent = $urandom_range(0, max_ent);
				put_le(gs, 2);
				put_le(nent, (t == sbe_mdd_pkg::TPL_TRADES) ? 4 : 2);
				pad = int'(gs) - ((t == sbe_mdd_pkg::TPL_TRADES) ? 24 : 16);
				for (int k = 0; k < nent; k++) begin
					put_le(pick64(), 8); put_le(pick64(), 8);
					if (t == sbe_mdd_pkg::TPL_TRADES) put_le(pick64(), 8);
					if (pad > 0) repeat (pad) put_byte(8'($urandom));
				end
			end
		end
		len = $urandom_range(0, 12);
		put_byte(8'(len));
		repeat (len) put_byte(8'($urandom));
		if (fault == F_TRAIL) repeat ($urandom_range(1, 10)) put_byte(8'($urandom));
		if (fault == F_CUT) wire_q = wire_q[0:$urandom_range(8, wire_q.size() - 2)];
		if (fault == F_SHORTHDR) wire_q = wire_q[0:$urandom_range(0, 6)];
	endtask

	function automatic logic [15:0] pick_tpl();
		return 16'(sbe_mdd_pkg::TPL_TRADES + $urandom_range(0, 3));
	endfunction

	task automatic test_templates();
		logic [15:0] t;
		t = sbe_mdd_pkg::TPL_TRADES;
		repeat (4) begin
			make_message(t, F_NONE, 2);
			send_message();
			t++;
		end
	endtask

	task automatic test_faults();
		int f;
		for (f = F_SCHEMA; f <= F_TRAIL; f++) begin
			make_message((f == F_TEMPLATE) ? 16'($urandom_range(0, 9999)) : pick_tpl(), f, 2);
			send_message();
		end
		// the largest template id is unknown too
		make_message(16'hffff, F_NONE, 1);
		send_message();
		// a group with no entries, and a single-byte message
		make_message(sbe_mdd_pkg::TPL_SNAP, F_NONE, 0);
		send_message();
		wire_q.delete();
		put_byte(8'hff);
		send_message();
	endtask

	task automatic random_messages(input int nbytes);
		int stop_at;
		int r;
		stop_at = sent_bytes + nbytes;
		while (sent_bytes < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			r = $urandom_range(0, 99);
			if (r < 55) make_message(pick_tpl(), F_NONE, 4);
			else if (r < 65) make_message(pick_tpl(), $urandom_range(0, 1) ? F_WIDE : F_TRAIL, 4);
			else if (r < 90) make_message(pick_tpl(), $urandom_range(F_SCHEMA, F_SHORTHDR), 4);
			else make_message(pick_tpl(), F_NOISE, 0);
			send_message();
		end
	endtask

	task automatic test_config_extremes();
		write_reg(sbe_mdd_pkg::CFG_SCHEMA, 16'h0000);
		write_reg(sbe_mdd_pkg::CFG_VERSION, 16'h0000);
		random_messages(100);
		write_reg(sbe_mdd_pkg::CFG_SCHEMA, 16'hffff);
		write_reg(sbe_mdd_pkg::CFG_VERSION, 16'hffff);
		random_messages(100);
		write_reg(sbe_mdd_pkg::CFG_SCHEMA, 16'($urandom));
		write_reg(sbe_mdd_pkg::CFG_VERSION, 16'($urandom));
	endtask

	task automatic test_output_stall();
		wait_idle();
		gap_max = 0;
		hold_req = 1;
		make_message(sbe_mdd_pkg::TPL_TRADES, F_NONE, 10);
		send_message();
		wait_idle();
		make_message(sbe_mdd_pkg::TPL_DIFF, F_NONE, 6);
		send_message();
		wait_idle();
	endtask

	initial begin
		int guard;
		clear_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_templates();
		test_faults();
		test_output_stall();
		test_config_extremes();
		random_messages(RANDOM_BYTES);
		write_reg(sbe_mdd_pkg::CFG_SCHEMA, 16'd1);
		write_reg(sbe_mdd_pkg::CFG_VERSION, 16'd0);
		random_messages(100);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_recs.size() != 0 && guard < WATCHDOG_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_recs.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
